/* hdl/hpcs_pkg.sv */
// ----------------------------------------------------------------------------
// hpcs_pkg
// Shared widths, controller states and the command/status bundles of the
// hash partition counting sort.
// ----------------------------------------------------------------------------
package hpcs_pkg;

    // fixed field widths of the ports
    localparam int HASH_W    = 32;
    localparam int LEVEL_W   = 4;
    localparam int ROW_IDX_W = 6;
    localparam int PART_ID_W = 9;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd2;

    // controller phases, one-hot
    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_COUNT  = 6'b000100,
        S_PREFIX = 6'b001000,
        S_PLACE  = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    // controller to datapath
    typedef struct packed {
        t_state state;
        logic   load;
        logic   load_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic done;
    } t_status;

endpackage

/* hdl/hpcs_ram.sv */
// ----------------------------------------------------------------------------
// hpcs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hpcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/hpcs_ctrl.sv */
// ----------------------------------------------------------------------------
// hpcs_ctrl
// Phase sequencer: clear after reset, load a batch, count, prefix sum,
// stable placement, then emission.
// ----------------------------------------------------------------------------
module hpcs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_last_row,
    output logic               o_in_ready,
    output hpcs_pkg::t_cmd     o_cmd,
    input  hpcs_pkg::t_status  i_status
);

    hpcs_pkg::t_state r_state;
    hpcs_pkg::t_state n_state;
    logic             load;

    // input beats are taken only while loading
    assign o_in_ready = (r_state == hpcs_pkg::S_LOAD);
    assign load       = i_in_valid && o_in_ready;

    // next phase
    always_comb begin
        n_state = r_state;
        case (r_state)
            hpcs_pkg::S_INIT: begin
                if (i_status.done) n_state = hpcs_pkg::S_LOAD;
            end
            hpcs_pkg::S_LOAD: begin
                if (load && i_last_row) n_state = hpcs_pkg::S_COUNT;
            end
            hpcs_pkg::S_COUNT: begin
                if (i_status.done) n_state = hpcs_pkg::S_PREFIX;
            end
            hpcs_pkg::S_PREFIX: begin
                if (i_status.done) n_state = hpcs_pkg::S_PLACE;
            end
            hpcs_pkg::S_PLACE: begin
                if (i_status.done) n_state = hpcs_pkg::S_EMIT;
            end
            hpcs_pkg::S_EMIT: begin
                if (i_status.done) n_state = hpcs_pkg::S_LOAD;
            end
            default: begin
                n_state = hpcs_pkg::S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpcs_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // command bundle
    assign o_cmd.state     = r_state;
    assign o_cmd.load      = load;
    assign o_cmd.load_last = load && i_last_row;

endmodule

/* hdl/hpcs_datapath.sv */
// ----------------------------------------------------------------------------
// hpcs_datapath
// Row store, per-partition count and offset memories, the read-modify-write
// pipeline for counting and placement, the prefix sum and the output stages.
// ----------------------------------------------------------------------------
module hpcs_datapath #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_LEVEL = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hpcs_pkg::t_cmd                      i_cmd,
    output hpcs_pkg::t_status                   o_status,
    input  logic                                i_cfg_we,
    input  logic [hpcs_pkg::LEVEL_W-1:0]        i_cfg_wdata,
    input  logic [hpcs_pkg::HASH_W-1:0]         i_hash,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hpcs_pkg::ROW_IDX_W-1:0]      o_row_index,
    output logic [hpcs_pkg::PART_ID_W-1:0]      o_part_id,
    output logic                                o_group_end,
    output logic                                o_last
);

    localparam int NS      = 1 << MAX_LEVEL;
    localparam int RW      = $clog2(MAX_ROWS);
    localparam int CW      = $clog2(MAX_ROWS + 1);
    localparam int IDX_MAX = (NS > MAX_ROWS) ? NS : MAX_ROWS;
    localparam int IW      = $clog2(IDX_MAX + 1);
    localparam int PIDW    = (MAX_LEVEL + 1 > hpcs_pkg::PART_ID_W) ?
                             MAX_LEVEL + 1 : hpcs_pkg::PART_ID_W;
    localparam int PLW     = MAX_LEVEL + RW;

    hpcs_pkg::t_state st;
    assign st = i_cmd.state;

    // configuration and batch state
    logic [hpcs_pkg::LEVEL_W-1:0] r_level;
    logic [hpcs_pkg::LEVEL_W-1:0] r_lv;
    logic [hpcs_pkg::LEVEL_W-1:0] eff_level;
    logic [CW-1:0]                r_rows;
    logic [IW-1:0]                r_idx;

    // rmw pipeline
    logic                 r_a_v;
    logic [RW-1:0]        r_a_row;
    logic [MAX_LEVEL-1:0] r_a_p;
    logic                 r_b_v;
    logic [MAX_LEVEL-1:0] r_b_s;
    logic [RW-1:0]        r_b_row;
    logic                 r_w_v;
    logic [MAX_LEVEL-1:0] r_w_s;
    logic [CW-1:0]        r_w_d;
    logic [CW-1:0]        r_acc;

    // emission stages
    logic                             r_qv;
    logic                             r_q_last;
    logic                             r_hv;
    logic                             r_h_last;
    logic [MAX_LEVEL-1:0]             r_h_s;
    logic [RW-1:0]                    r_h_row;
    logic                             r_ov;
    logic [hpcs_pkg::ROW_IDX_W-1:0]   r_o_row;
    logic [hpcs_pkg::PART_ID_W-1:0]   r_o_pid;
    logic                             r_o_ge;
    logic                             r_o_last;

    // memory ports
    logic                 rp_we, rp_re;
    logic [RW-1:0]        rp_waddr, rp_raddr;
    logic [MAX_LEVEL-1:0] rp_wdata, rp_q;
    logic                 cnt_we, cnt_re;
    logic [MAX_LEVEL-1:0] cnt_waddr, cnt_raddr;
    logic [CW-1:0]        cnt_wdata, cnt_q;
    logic                 off_we, off_re;
    logic [MAX_LEVEL-1:0] off_waddr, off_raddr;
    logic [CW-1:0]        off_wdata, off_q;
    logic                 pl_we, pl_re;
    logic [RW-1:0]        pl_waddr, pl_raddr;
    logic [PLW-1:0]       pl_wdata, pl_q;

    // misc combinational
    logic [MAX_LEVEL-1:0] mask;
    logic [IW-1:0]        nparts;
    logic [IW-1:0]        n_ext;
    logic [IW-1:0]        lim;
    logic                 more;
    logic [IW-1:0]        place_row;
    logic [MAX_LEVEL-1:0] b_s;
    logic [CW-1:0]        fwd_cur;
    logic [CW-1:0]        upd;
    logic [CW-1:0]        acc_new;
    logic                 rmw_phase;
    logic                 adv;
    logic                 done;
    logic                 o_take, o_free;
    logic                 h_to_o, q_to_h, rd_en;
    logic [MAX_LEVEL-1:0] q_s;
    logic [RW-1:0]        q_row;
    logic [PIDW-1:0]      h_pid;

    // level clamp and mask
    assign eff_level = (r_level > hpcs_pkg::LEVEL_W'(MAX_LEVEL)) ?
                       hpcs_pkg::LEVEL_W'(MAX_LEVEL) : r_level;

    always_comb begin
        for (int j = 0; j < MAX_LEVEL; j++) begin
            mask[j] = (r_lv > hpcs_pkg::LEVEL_W'(j));
        end
    end

    assign nparts    = IW'(1) << r_lv;
    assign n_ext     = IW'(r_rows);
    assign place_row = n_ext - IW'(1) - r_idx;
    assign rmw_phase = (st == hpcs_pkg::S_COUNT) || (st == hpcs_pkg::S_PLACE);

    // sweep length of the current phase
    always_comb begin
        case (st)
            hpcs_pkg::S_INIT:   lim = IW'(NS);
            hpcs_pkg::S_PREFIX: lim = nparts;
            hpcs_pkg::S_COUNT,
            hpcs_pkg::S_PLACE,
            hpcs_pkg::S_EMIT:   lim = n_ext;
            default:            lim = '0;
        endcase
    end
    assign more = (r_idx < lim);

    // rmw with forwarding of the previous write to the same slot
    assign b_s     = rp_q & mask;
    assign fwd_cur = (r_w_v && (r_w_s == r_b_s)) ? r_w_d :
                     ((st == hpcs_pkg::S_COUNT) ? cnt_q : off_q);
    assign upd     = (st == hpcs_pkg::S_COUNT) ? fwd_cur + CW'(1) : fwd_cur - CW'(1);
    assign acc_new = r_acc + cnt_q;

    // emission handshake between ram output, hold stage and output register
    assign q_s    = pl_q[PLW-1:RW];
    assign q_row  = pl_q[RW-1:0];
    assign o_take = r_ov && i_out_ready;
    assign o_free = !r_ov || o_take;
    assign h_to_o = r_hv && o_free && (r_h_last || r_qv);
    assign q_to_h = r_qv && (!r_hv || h_to_o);
    assign rd_en  = (st == hpcs_pkg::S_EMIT) && more && (!r_qv || q_to_h);
    assign h_pid  = PIDW'(r_h_s) | (PIDW'(1) << r_lv);

    // memory port steering per phase
    always_comb begin
        rp_we     = 1'b0;
        rp_waddr  = r_rows[RW-1:0];
        rp_wdata  = i_hash[MAX_LEVEL-1:0];
        rp_re     = 1'b0;
        rp_raddr  = r_idx[RW-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = r_b_s;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = b_s;
        off_we    = 1'b0;
        off_waddr = r_b_s;
        off_wdata = upd;
        off_re    = 1'b0;
        off_raddr = b_s;
        pl_we     = 1'b0;
        pl_waddr  = upd[RW-1:0];
        pl_wdata  = {r_b_s, r_b_row};
        pl_re     = 1'b0;
        pl_raddr  = r_idx[RW-1:0];
        adv       = 1'b0;
        done      = 1'b0;
        case (st)
            hpcs_pkg::S_INIT: begin
                cnt_we    = more;
                cnt_waddr = r_idx[MAX_LEVEL-1:0];
                adv       = more;
                done      = !more;
            end
            hpcs_pkg::S_LOAD: begin
                rp_we = i_cmd.load && (r_rows < CW'(MAX_ROWS));
            end
            hpcs_pkg::S_COUNT: begin
                rp_re     = more;
                cnt_re    = r_a_v;
                cnt_we    = r_b_v;
                cnt_wdata = upd;
                adv       = more;
                done      = !more && !r_a_v && !r_b_v;
            end
            hpcs_pkg::S_PREFIX: begin
                cnt_re    = more;
                cnt_raddr = r_idx[MAX_LEVEL-1:0];
                cnt_we    = r_a_v;
                cnt_waddr = r_a_p;
                off_we    = r_a_v;
                off_waddr = r_a_p;
                off_wdata = acc_new;
                adv       = more;
                done      = !more && !r_a_v;
            end
            hpcs_pkg::S_PLACE: begin
                rp_re    = more;
                rp_raddr = place_row[RW-1:0];
                off_re   = r_a_v;
                off_we   = r_b_v;
                pl_we    = r_b_v;
                adv      = more;
                done     = !more && !r_a_v && !r_b_v;
            end
            hpcs_pkg::S_EMIT: begin
                pl_re = rd_en;
                adv   = rd_en;
                done  = o_take && r_o_last;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    assign o_status.done = done;

    // row store: low hash bits of each row
    hpcs_ram #(.WIDTH(MAX_LEVEL), .DEPTH(MAX_ROWS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (rp_we),
        .i_waddr (rp_waddr),
        .i_wdata (rp_wdata),
        .i_re    (rp_re),
        .i_raddr (rp_raddr),
        .o_rdata (rp_q)
    );

    // per-partition counts, zero between batches
    hpcs_ram #(.WIDTH(CW), .DEPTH(NS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_q)
    );

    // per-partition end offsets, decremented during placement
    hpcs_ram #(.WIDTH(CW), .DEPTH(NS)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_waddr (off_waddr),
        .i_wdata (off_wdata),
        .i_re    (off_re),
        .i_raddr (off_raddr),
        .o_rdata (off_q)
    );

    // placed rows in output order, partition and row index
    hpcs_ram #(.WIDTH(PLW), .DEPTH(MAX_ROWS)) u_place_ram (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_re    (pl_re),
        .i_raddr (pl_raddr),
        .o_rdata (pl_q)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= hpcs_pkg::LEVEL_RESET;
            r_lv    <= hpcs_pkg::LEVEL_RESET;
            r_rows  <= '0;
            r_idx   <= '0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_w_v   <= 1'b0;
            r_acc   <= '0;
            r_qv    <= 1'b0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) r_level <= i_cfg_wdata;
            if (i_cmd.load_last) r_lv <= eff_level;

            // row count of the batch
            if (rp_we) begin
                r_rows <= r_rows + CW'(1);
            end else if ((st == hpcs_pkg::S_EMIT) && done) begin
                r_rows <= '0;
            end

            // sweep index
            if (done) begin
                r_idx <= '0;
            end else if (adv) begin
                r_idx <= r_idx + IW'(1);
            end

            r_a_v <= (rmw_phase || (st == hpcs_pkg::S_PREFIX)) && more;
            r_b_v <= rmw_phase && r_a_v;
            r_w_v <= rmw_phase && r_b_v;

            // running prefix sum
            if (st != hpcs_pkg::S_PREFIX) begin
                r_acc <= '0;
            end else if (r_a_v) begin
                r_acc <= acc_new;
            end

            // emission stage valids
            if (rd_en) begin
                r_qv <= 1'b1;
            end else if (q_to_h) begin
                r_qv <= 1'b0;
            end
            if (q_to_h) begin
                r_hv <= 1'b1;
            end else if (h_to_o) begin
                r_hv <= 1'b0;
            end
            if (h_to_o) begin
                r_ov <= 1'b1;
            end else if (o_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_a_row <= place_row[RW-1:0];
        r_a_p   <= r_idx[MAX_LEVEL-1:0];
        r_b_s   <= b_s;
        r_b_row <= r_a_row;
        r_w_s   <= r_b_s;
        r_w_d   <= upd;
        if (rd_en) begin
            r_q_last <= (r_idx == n_ext - IW'(1));
        end
        if (q_to_h) begin
            r_h_last <= r_q_last;
            r_h_s    <= q_s;
            r_h_row  <= q_row;
        end
        if (h_to_o) begin
            r_o_row  <= hpcs_pkg::ROW_IDX_W'(r_h_row);
            r_o_pid  <= h_pid[hpcs_pkg::PART_ID_W-1:0];
            r_o_ge   <= r_h_last || (r_h_s != q_s);
            r_o_last <= r_h_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_row_index = r_o_row;
    assign o_part_id   = r_o_pid;
    assign o_group_end = r_o_ge;
    assign o_last      = r_o_last;

    // placement never decrements an offset below zero
    a_place_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st == hpcs_pkg::S_PLACE) && r_b_v |-> fwd_cur != '0)
        else $error("placement offset underflow");

    // prefix sum covers exactly the stored rows
    a_prefix_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st == hpcs_pkg::S_PREFIX) && done |-> r_acc == r_rows)
        else $error("prefix sum does not match row count");

    // the final beat always closes its group
    a_last_closes_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_last |-> r_o_ge)
        else $error("last beat without group end");

    // emission pipeline is empty once the final beat is taken
    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && r_o_last |=> !r_ov && !r_hv && !r_qv)
        else $error("emission stages not drained after final beat");

endmodule

/* hdl/hash_partition_counting_sort.sv */
// ----------------------------------------------------------------------------
// hash_partition_counting_sort
// Collects a batch of row hashes and emits the row indices grouped by
// partition in ascending order, stable within each group.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready): one beat per row carrying i_hash and
//   i_last_row; rows are taken at one per cycle while the block is loading.
//   Rows past MAX_ROWS are dropped, but a dropped last row still ends the batch.
//   Output channel (o_out_valid/i_out_ready): one beat per stored row with
//   o_row_index, o_part_id, o_group_end and o_last.
//   After the last row, the block counts the rows per partition, forms the
//   prefix sum of the counts and places the rows stably, through the
//   one-read-one-write ports of the count and offset memories; emission then
//   follows, and results leave at one per cycle while the receiver is ready.
//   The next batch is accepted once the final beat is taken.
//   i_cfg_we writes the partition level; it is sampled when the last row
//   is taken.
//   After reset the count memory is cleared, one entry a cycle, over all
//   2^MAX_LEVEL entries; no rows are accepted during that pass.
//   When the receiver stalls, the output beat holds and emission pauses.
// ----------------------------------------------------------------------------
module hash_partition_counting_sort #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_LEVEL = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hpcs_pkg::LEVEL_W-1:0]    i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [hpcs_pkg::HASH_W-1:0]     i_hash,
    input  logic                            i_last_row,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [hpcs_pkg::ROW_IDX_W-1:0]  o_row_index,
    output logic [hpcs_pkg::PART_ID_W-1:0]  o_part_id,
    output logic                            o_group_end,
    output logic                            o_last
);

    hpcs_pkg::t_cmd    cmd;
    hpcs_pkg::t_status status;

    // phase sequencer
    hpcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last_row (i_last_row),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // memories and pipelines
    hpcs_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_LEVEL (MAX_LEVEL)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_hash      (i_hash),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_row_index (o_row_index),
        .o_part_id   (o_part_id),
        .o_group_end (o_group_end),
        .o_last      (o_last)
    );

endmodule
